// ===== rtl/core/selective_repeat_arq_assert.svh =====
// assertion macros used by the datapath rtl file srarq_dp.sv
`ifndef SELECTIVE_REPEAT_ARQ_ASSERT_SVH
`define SELECTIVE_REPEAT_ARQ_ASSERT_SVH

// same-cycle implication, sampled on the rising clock edge
`define SRA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, sampled on the rising clock edge
`define SRA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/srarq_pkg.sv =====
// types, codes and helper functions of the selective repeat arq engine
package srarq_pkg;

    localparam int PEERS      = 4;
    localparam int WINDOW     = 4;
    localparam int SEQ_BITS   = 7;
    localparam int PAY_BITS   = 32;
    localparam int TIM_BITS   = 16;
    localparam int SLOTS      = PEERS * WINDOW;

    // request types
    localparam logic [1:0] REQ_SEND  = 2'd0;
    localparam logic [1:0] REQ_FRAME = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    // received frame kinds
    localparam logic [1:0] FK_DATA = 2'd0;
    localparam logic [1:0] FK_ACK  = 2'd1;
    localparam logic [1:0] FK_NAK  = 2'd2;

    // result kinds
    localparam logic [2:0] OK_DATA    = 3'd0;
    localparam logic [2:0] OK_ACK     = 3'd1;
    localparam logic [2:0] OK_NAK     = 3'd2;
    localparam logic [2:0] OK_DELIVER = 3'd3;
    localparam logic [2:0] OK_STATUS  = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_FRAME_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_ACK_TIMEOUT   = 2'd1;

    typedef struct packed {
        logic idle;
        logic accept;
        logic send;
        logic nak;
        logic store;
        logic dlv_rd;
        logic dlv_em;
        logic nakr;
        logic rs_em;
        logic ackloop;
        logic tack;
        logic tft;
        logic tem;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic       in_valid;
        logic [1:0] in_req;
        logic [1:0] in_kind;
        logic       emit_ok;
        logic       bc_room;
        logic       nak_cond;
        logic       store_ok;
        logic       dlv_hit;
        logic       rs_ok;
        logic       ack_more;
        logic       ack_expire;
        logic       ft_expire;
        logic       j_last;
        logic       q_last;
    } t_stat;

    // b lies in the circular range [a, c)
    function automatic logic in_window(logic [SEQ_BITS-1:0] a, logic [SEQ_BITS-1:0] b,
                                       logic [SEQ_BITS-1:0] c);
        return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
    endfunction

    // a zero timeout loads as one
    function automatic logic [TIM_BITS-1:0] load_timer(logic [TIM_BITS-1:0] t);
        return (t == '0) ? TIM_BITS'(1) : t;
    endfunction

endpackage

// ===== rtl/core/srarq_ctrl.sv =====
// controller state machine of the selective repeat arq engine
module srarq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  srarq_pkg::t_stat i_st,
    output srarq_pkg::t_cmd  o_cmd
);
    import srarq_pkg::*;

    typedef enum logic [14:0] {
        ST_IDLE    = 15'h0001,
        ST_SEND    = 15'h0002,
        ST_NAK     = 15'h0004,
        ST_STORE   = 15'h0008,
        ST_DLV_RD  = 15'h0010,
        ST_DLV_EM  = 15'h0020,
        ST_NAKR    = 15'h0040,
        ST_RS_EM   = 15'h0080,
        ST_ACKLOOP = 15'h0100,
        ST_TACK    = 15'h0200,
        ST_TFT     = 15'h0400,
        ST_TEM     = 15'h0800,
        ST_FIN     = 15'h1000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_st.in_valid) begin
                    case (i_st.in_req)
                        REQ_SEND:  n_state = ST_SEND;
                        REQ_FRAME: begin
                            if (i_st.in_kind == FK_DATA) begin
                                n_state = ST_NAK;
                            end else if (i_st.in_kind == FK_NAK) begin
                                n_state = ST_NAKR;
                            end else begin
                                n_state = ST_ACKLOOP;
                            end
                        end
                        REQ_TICK:  n_state = ST_TACK;
                        default:   n_state = ST_FIN;
                    endcase
                end
            end
            ST_SEND: begin
                if (!i_st.bc_room || i_st.emit_ok) n_state = ST_FIN;
            end
            ST_NAK: begin
                if (!i_st.nak_cond || i_st.emit_ok) n_state = ST_STORE;
            end
            ST_STORE: begin
                n_state = i_st.store_ok ? ST_DLV_RD : ST_ACKLOOP;
            end
            ST_DLV_RD: begin
                n_state = i_st.dlv_hit ? ST_DLV_EM : ST_ACKLOOP;
            end
            ST_DLV_EM: begin
                if (i_st.emit_ok) n_state = ST_DLV_RD;
            end
            ST_NAKR: begin
                n_state = i_st.rs_ok ? ST_RS_EM : ST_ACKLOOP;
            end
            ST_RS_EM: begin
                if (i_st.emit_ok) n_state = ST_ACKLOOP;
            end
            ST_ACKLOOP: begin
                if (!i_st.ack_more) n_state = ST_FIN;
            end
            ST_TACK: begin
                if (!i_st.ack_expire || i_st.emit_ok) n_state = ST_TFT;
            end
            ST_TFT: begin
                if (i_st.ft_expire) begin
                    n_state = ST_TEM;
                end else if (i_st.j_last) begin
                    n_state = i_st.q_last ? ST_FIN : ST_TACK;
                end
            end
            ST_TEM: begin
                if (i_st.emit_ok) begin
                    if (i_st.j_last) begin
                        n_state = i_st.q_last ? ST_FIN : ST_TACK;
                    end else begin
                        n_state = ST_TFT;
                    end
                end
            end
            ST_FIN: begin
                if (i_st.emit_ok) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.idle    = (r_state == ST_IDLE);
        o_cmd.accept  = (r_state == ST_IDLE) && i_st.in_valid;
        o_cmd.send    = (r_state == ST_SEND);
        o_cmd.nak     = (r_state == ST_NAK);
        o_cmd.store   = (r_state == ST_STORE);
        o_cmd.dlv_rd  = (r_state == ST_DLV_RD);
        o_cmd.dlv_em  = (r_state == ST_DLV_EM);
        o_cmd.nakr    = (r_state == ST_NAKR);
        o_cmd.rs_em   = (r_state == ST_RS_EM);
        o_cmd.ackloop = (r_state == ST_ACKLOOP);
        o_cmd.tack    = (r_state == ST_TACK);
        o_cmd.tft     = (r_state == ST_TFT);
        o_cmd.tem     = (r_state == ST_TEM);
        o_cmd.fin     = (r_state == ST_FIN);
    end

endmodule

// ===== rtl/core/srarq_dp.sv =====
// datapath of the selective repeat arq engine: windows, timers, stores, output register
`include "selective_repeat_arq_assert.svh"
module srarq_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  srarq_pkg::t_cmd  i_cmd,
    output srarq_pkg::t_stat o_st,
    input  logic             i_s_tvalid,
    input  logic [47:0]      i_s_tdata,
    input  logic [3:0]       i_s_tuser,
    input  logic             i_cfg_valid,
    input  logic [1:0]       i_cfg_addr,
    input  logic [15:0]      i_cfg_data,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [55:0]      o_m_tdata,
    output logic [2:0]       o_m_tuser,
    output logic             o_m_tlast
);
    import srarq_pkg::*;

    localparam int PB = $clog2(PEERS);
    localparam int WB = $clog2(WINDOW);
    localparam int SB = $clog2(SLOTS);

    logic [TIM_BITS-1:0] r_cfg_ft, r_cfg_at;

    logic [PB-1:0]       r_peer;
    logic [SEQ_BITS-1:0] r_seq, r_ack;
    logic [PAY_BITS-1:0] r_pay;

    logic [SEQ_BITS-1:0] r_sl [PEERS];
    logic [SEQ_BITS-1:0] r_sn [PEERS];
    logic [SEQ_BITS-1:0] r_rl [PEERS];
    logic [SEQ_BITS-1:0] r_rh [PEERS];
    logic [2:0]          r_bc [PEERS];
    logic                r_nak [PEERS];
    logic [TIM_BITS-1:0] r_at [PEERS];
    logic                r_arr [SLOTS];
    logic [TIM_BITS-1:0] r_ft [SLOTS];
    logic [SEQ_BITS-1:0] r_fs [SLOTS];

    logic [PAY_BITS-1:0] m_out [SLOTS];
    logic [PAY_BITS-1:0] m_in  [SLOTS];
    logic [PAY_BITS-1:0] r_rd_out, r_rd_in;

    logic [2:0]    r_i;
    logic [PB-1:0] r_q;
    logic [WB-1:0] r_j;

    logic          r_ov;
    logic [2:0]    r_o_kind;
    logic [1:0]    r_o_peer;
    logic [6:0]    r_o_seq, r_o_ack;
    logic [31:0]   r_o_pay;
    logic [3:0]    r_o_mask;
    logic          r_o_last;

    logic [PB-1:0]       w_p;
    logic [SEQ_BITS-1:0] w_sl, w_sn, w_rl, w_rh, w_r, w_ackof;
    logic [SB-1:0]       w_k, w_kseq, w_krl, w_kr, w_ksl, w_rd_addr;
    logic                w_emit_ok, w_load, w_tick;
    logic                w_advance;
    logic [3:0]          w_mask;

    t_stat w_st;
    logic [2:0]    n_kind;
    logic [1:0]    n_peer;
    logic [6:0]    n_seq, n_ack;
    logic [31:0]   n_pay;
    logic          n_last;

    assign w_tick  = i_cmd.tack || i_cmd.tft || i_cmd.tem;
    assign w_p     = w_tick ? r_q : r_peer;
    assign w_sl    = r_sl[w_p];
    assign w_sn    = r_sn[w_p];
    assign w_rl    = r_rl[w_p];
    assign w_rh    = r_rh[w_p];
    assign w_ackof = w_rl - SEQ_BITS'(1);
    assign w_r     = r_ack + SEQ_BITS'(1);
    assign w_k     = {r_q, r_j};
    assign w_kseq  = {r_peer, r_seq[WB-1:0]};
    assign w_krl   = {r_peer, w_rl[WB-1:0]};
    assign w_kr    = {r_peer, w_r[WB-1:0]};
    assign w_ksl   = {r_peer, w_sl[WB-1:0]};
    assign w_emit_ok = !r_ov || i_m_tready;
    assign w_advance = (i_cmd.tft && !w_st.ft_expire) || (i_cmd.tem && w_emit_ok);

    always_comb begin
        w_mask = '0;
        for (int q = 0; q < PEERS; q++) begin
            w_mask[q] = (r_bc[q] < 3'(WINDOW));
        end
    end

    always_comb begin
        w_st            = '0;
        w_st.in_valid   = i_s_tvalid;
        w_st.in_req     = i_s_tuser[1:0];
        w_st.in_kind    = i_s_tuser[3:2];
        w_st.emit_ok    = w_emit_ok;
        w_st.bc_room    = (r_bc[r_peer] < 3'(WINDOW));
        w_st.nak_cond   = (r_seq != w_rl) && r_nak[r_peer];
        w_st.store_ok   = in_window(w_rl, r_seq, w_rh) && !r_arr[w_kseq];
        w_st.dlv_hit    = r_arr[w_krl] && (r_i < 3'(WINDOW));
        w_st.rs_ok      = in_window(w_sl, w_r, w_sn);
        w_st.ack_more   = in_window(w_sl, r_ack, w_sn);
        w_st.ack_expire = (r_at[r_q] == TIM_BITS'(1));
        w_st.ft_expire  = (r_ft[w_k] == TIM_BITS'(1));
        w_st.j_last     = (r_j == WB'(WINDOW - 1));
        w_st.q_last     = (r_q == PB'(PEERS - 1));
    end
    assign o_st = w_st;

    // result selection
    always_comb begin
        w_load = 1'b0;
        n_kind = OK_STATUS;
        n_peer = w_p;
        n_seq  = '0;
        n_ack  = w_ackof;
        n_pay  = '0;
        n_last = 1'b0;
        if (i_cmd.send && w_st.bc_room) begin
            w_load = 1'b1;
            n_kind = OK_DATA;
            n_seq  = w_sn;
            n_pay  = r_pay;
        end else if (i_cmd.nak && w_st.nak_cond) begin
            w_load = 1'b1;
            n_kind = OK_NAK;
        end else if (i_cmd.dlv_em) begin
            w_load = 1'b1;
            n_kind = OK_DELIVER;
            n_ack  = '0;
            n_pay  = r_rd_in;
        end else if (i_cmd.rs_em) begin
            w_load = 1'b1;
            n_kind = OK_DATA;
            n_seq  = w_r;
            n_pay  = r_rd_out;
        end else if (i_cmd.tack && w_st.ack_expire) begin
            w_load = 1'b1;
            n_kind = OK_ACK;
        end else if (i_cmd.tem) begin
            w_load = 1'b1;
            n_kind = OK_DATA;
            n_seq  = r_fs[w_k];
            n_pay  = r_rd_out;
        end else if (i_cmd.fin) begin
            w_load = 1'b1;
            n_kind = OK_STATUS;
            n_peer = '0;
            n_ack  = '0;
            n_last = 1'b1;
        end
        w_load = w_load && w_emit_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_load) begin
            r_ov <= 1'b1;
        end else if (i_m_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_kind <= n_kind;
            r_o_peer <= n_peer;
            r_o_seq  <= n_seq;
            r_o_ack  <= n_ack;
            r_o_pay  <= n_pay;
            r_o_mask <= n_last ? w_mask : 4'd0;
            r_o_last <= n_last;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tuser  = r_o_kind;
    assign o_m_tlast  = r_o_last;
    assign o_m_tdata  = {4'd0, r_o_mask, r_o_pay, r_o_ack, r_o_seq, r_o_peer};

    // input field capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peer <= '0;
        end else if (i_cmd.accept) begin
            r_peer <= i_s_tdata[1:0];
            r_seq  <= i_s_tdata[8:2];
            r_ack  <= i_s_tdata[15:9];
            r_pay  <= i_s_tdata[47:16];
        end
    end

    // packet stores, the resend slot stays addressed while its frame waits
    assign w_rd_addr = (i_cmd.nakr || i_cmd.rs_em) ? w_kr : w_k;

    always_ff @(posedge i_clk) begin
        if (i_cmd.send && w_st.bc_room && w_emit_ok) begin
            m_out[{r_peer, w_sn[WB-1:0]}] <= r_pay;
        end
        r_rd_out <= m_out[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store && w_st.store_ok) begin
            m_in[w_kseq] <= r_pay;
        end
        r_rd_in <= m_in[w_krl];
    end

    // window and timer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_ft <= TIM_BITS'(100);
            r_cfg_at <= TIM_BITS'(20);
            r_i <= '0;
            r_q <= '0;
            r_j <= '0;
            for (int p = 0; p < PEERS; p++) begin
                r_sl[p]  <= '0;
                r_sn[p]  <= '0;
                r_rl[p]  <= '0;
                r_rh[p]  <= SEQ_BITS'(WINDOW);
                r_bc[p]  <= '0;
                r_nak[p] <= 1'b1;
                r_at[p]  <= '0;
            end
            for (int k = 0; k < SLOTS; k++) begin
                r_arr[k] <= 1'b0;
                r_ft[k]  <= '0;
                r_fs[k]  <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_addr == CFG_FRAME_TIMEOUT) r_cfg_ft <= i_cfg_data;
                if (i_cfg_addr == CFG_ACK_TIMEOUT)   r_cfg_at <= i_cfg_data;
            end
            if (i_cmd.accept) begin
                r_q <= '0;
                r_j <= '0;
            end
            // packet to send
            if (i_cmd.send && w_st.bc_room && w_emit_ok) begin
                r_bc[r_peer] <= r_bc[r_peer] + 3'd1;
                r_sn[r_peer] <= w_sn + SEQ_BITS'(1);
                r_ft[{r_peer, w_sn[WB-1:0]}] <= load_timer(r_cfg_ft);
                r_fs[{r_peer, w_sn[WB-1:0]}] <= w_sn;
                r_at[r_peer] <= '0;
            end
            // nak on an out-of-order data frame while its nak flag is set, else start an idle ack timer
            if (i_cmd.nak) begin
                if (w_st.nak_cond) begin
                    if (w_emit_ok) begin
                        r_nak[r_peer] <= 1'b0;
                        r_at[r_peer]  <= '0;
                    end
                end else if (r_at[r_peer] == '0) begin
                    r_at[r_peer] <= load_timer(r_cfg_at);
                end
            end
            if (i_cmd.store && w_st.store_ok) begin
                r_arr[w_kseq] <= 1'b1;
                r_i <= '0;
            end
            // in-order delivery
            if (i_cmd.dlv_em && w_emit_ok) begin
                r_nak[r_peer] <= 1'b1;
                r_arr[w_krl]  <= 1'b0;
                r_rl[r_peer]  <= w_rl + SEQ_BITS'(1);
                r_rh[r_peer]  <= w_rh + SEQ_BITS'(1);
                if (r_at[r_peer] == '0) r_at[r_peer] <= load_timer(r_cfg_at);
                r_i <= r_i + 3'd1;
            end
            // resend on nak
            if (i_cmd.rs_em && w_emit_ok) begin
                r_ft[w_kr]   <= load_timer(r_cfg_ft);
                r_fs[w_kr]   <= w_r;
                r_at[r_peer] <= '0;
            end
            // slide the send window up to the acknowledged frame
            if (i_cmd.ackloop && w_st.ack_more) begin
                if (r_bc[r_peer] != 3'd0) r_bc[r_peer] <= r_bc[r_peer] - 3'd1;
                r_ft[w_ksl]  <= '0;
                r_sl[r_peer] <= w_sl + SEQ_BITS'(1);
            end
            // tick walk
            if (i_cmd.tack && (r_at[r_q] != '0) && (!w_st.ack_expire || w_emit_ok)) begin
                r_at[r_q] <= r_at[r_q] - TIM_BITS'(1);
            end
            if (i_cmd.tft && (r_ft[w_k] != '0) && !w_st.ft_expire) begin
                r_ft[w_k] <= r_ft[w_k] - TIM_BITS'(1);
            end
            if (i_cmd.tem && w_emit_ok) begin
                r_ft[w_k] <= load_timer(r_cfg_ft);
                r_at[r_q] <= '0;
            end
            if (w_advance) begin
                r_j <= r_j + WB'(1);
                if (w_st.j_last) r_q <= r_q + PB'(1);
            end
        end
    end

    `SRA_ASSERT_NOW(a_load_room, w_load, !r_ov || i_m_tready)
    `SRA_ASSERT_NOW(a_status_fin, w_load && n_last, i_cmd.fin)
    `SRA_ASSERT_NEXT(a_accept_clears, i_cmd.accept, (r_q == '0) && (r_j == '0))
    `SRA_ASSERT_NOW(a_bc_bound, 1'b1, r_bc[r_peer] <= 3'(WINDOW))

endmodule

// ===== rtl/core/selective_repeat_arq.sv =====
// a result is loaded into the output register by the step that makes it; status ends each item
// a send item runs the send and status steps; a received frame runs the nak, store, delivery,
// resend and ack steps that its kind needs; the tick walk visits each ack and frame timer
// the next item is accepted after the status transfer has been loaded into the output register
// reset is synchronous active low: windows, marks, timers and timeouts return to their defaults
// the packet stores need no clearing pass and hold their contents across reset
module selective_repeat_arq (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // peer[1:0], frame_seq[8:2], frame_ack[15:9], payload[47:16]
    input  logic [3:0]  i_s_tuser,   // req_type[1:0], rx_kind[3:2]
    // result items
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata,   // out_peer[1:0], out_seq[8:2], out_ack[15:9],
                                     // out_payload[47:16], credit_mask[51:48], zero pad
    output logic [2:0]  o_m_tuser,   // out_kind[2:0]
    output logic        o_m_tlast,   // last result of the item
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_addr,  // 0 frame_timeout, 1 ack_timeout
    input  logic [15:0] i_cfg_data
);
    import srarq_pkg::*;

    t_cmd  w_cmd;
    t_stat w_st;

    // controller sequences one item at a time through its steps
    srarq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_st    (w_st),
        .o_cmd   (w_cmd)
    );

    // datapath holds all window state, timers, stores and the output register
    srarq_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_st        (w_st),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    // a new item transfer is taken only between items
    assign o_s_tready  = w_cmd.idle;
    // config writes are always accepted and registered
    assign o_cfg_ready = 1'b1;

endmodule
